>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the sorted table search core.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

>>> hw/rtl/stbs_pkg.sv
// Package for the sorted table search core: field widths, codes, command type.
// No dependencies.
package stbs_pkg;

	localparam int CW = 11;
	localparam int IW = 10;
	localparam int WW = 32;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		MODE_EXACT  = 2'd0,
		MODE_FLOOR  = 2'd1,
		MODE_INSERT = 2'd2
	} mode_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [IW-1:0]   idx;
		logic [WW-1:0]   word;
		logic [CW-1:0]   count;
		mode_t           mode;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} eng_state_t;

endpackage

>>> hw/rtl/sorted_table_binary_search_core.sv
// Sorted table search core: out_valid rises once an accepted search transaction has run its
// probes, at most floor(log2(TABLE_DEPTH))+1 of them, ending early on a hit; each probe is a
// registered table read followed by a compare.
// Back end: one write per cycle while idle; a search holds the engine until its result is loaded,
// longer while a prior result waits on out_ready; a two-entry queue decouples it from the input.
// Reset clears the queue and the engine state; table contents are undefined until written.
module sorted_table_binary_search_core import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            kind,
	input  logic [IW-1:0]   entry_index,
	input  logic [WW-1:0]   word,
	input  logic [CW-1:0]   valid_count,
	input  logic [1:0]      mode,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CW-1:0]   position,
	output logic            found
);

	logic q_full, q_push, q_pop, q_nonempty;
	cmd_t push_cmd, pop_cmd;

	stbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.entry_index (entry_index),
		.word        (word),
		.valid_count (valid_count),
		.mode        (mode),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	stbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.nonempty (q_nonempty)
	);

	stbs_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_cmd      (pop_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.found      (found)
	);

endmodule

>>> hw/rtl/stbs_front.sv
// Front end: accepts input transactions, drops out-of-range writes, clamps the
// count and decodes the mode into a command. Depends on stbs_pkg.
module stbs_front import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            kind,
	input  logic [IW-1:0]   entry_index,
	input  logic [WW-1:0]   word,
	input  logic [CW-1:0]   valid_count,
	input  logic [1:0]      mode,
	input  logic            q_full,
	output logic            q_push,
	output cmd_t            q_cmd
);

	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	logic drop;

	assign in_ready = !q_full;
	assign drop     = (kind == KIND_WRITE) && (32'(entry_index) >= DEPTH32);
	assign q_push   = in_valid && in_ready && !drop;

	always_comb begin
		q_cmd.op    = (kind == KIND_SEARCH) ? OP_SEARCH : OP_WRITE;
		q_cmd.idx   = entry_index;
		q_cmd.word  = word;
		q_cmd.count = (32'(valid_count) > DEPTH32) ? CW'(TABLE_DEPTH) : valid_count;
		unique case (mode)
			MODE_FLOOR:  q_cmd.mode = MODE_FLOOR;
			MODE_INSERT: q_cmd.mode = MODE_INSERT;
			default:     q_cmd.mode = MODE_EXACT;
		endcase
	end

endmodule

>>> hw/rtl/stbs_queue.sv
// Two-entry command queue between the front end and the search engine.
// Depends on stbs_pkg and assert_macros.svh.
module stbs_queue import stbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic nonempty
);

`include "assert_macros.svh"

	cmd_t            slot_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;

	assign full     = (cnt_q == QCW'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	`ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt_q < QCW'(QDEPTH))
	`ASSERT_IMP(a_no_underflow, clk, arst_n, pop, cnt_q != '0)
	`ASSERT_NXT(a_fill_step, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

>>> hw/rtl/stbs_engine.sv
// Back end: table memory, bisection sequencer and output register.
// Depends on stbs_pkg and assert_macros.svh.
module stbs_engine import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  cmd_t            q_cmd,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CW-1:0]   position,
	output logic            found
);

`include "assert_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [WW-1:0]  mem [TABLE_DEPTH];

	eng_state_t     st_q, st_d;
	logic [CW-1:0]  lo_q, hi_q, cnt_q, mid_q;
	logic [WW-1:0]  key_q, rdata_q;
	mode_t          mode_q;
	logic [CW-1:0]  res_pos_q;
	logic           res_found_q;
	logic           out_valid_q;
	logic [CW-1:0]  out_pos_q;
	logic           out_found_q;

	logic           active;
	logic [CW-1:0]  mid;
	logic [CW-1:0]  miss_pos;
	logic           out_free;
	logic           mem_we, mem_re, load_cmd, load_out;

	assign active   = (lo_q < hi_q);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (mode_q)
			MODE_FLOOR:  miss_pos = (hi_q != '0) ? (hi_q - 1'b1) : cnt_q;
			MODE_INSERT: miss_pos = hi_q;
			MODE_EXACT:  miss_pos = cnt_q;
			default:     miss_pos = cnt_q;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (q_nonempty && q_cmd.op == OP_SEARCH) st_d = ST_PROBE;
			ST_PROBE: st_d = active ? ST_CMP : ST_DONE;
			ST_CMP:   st_d = (rdata_q == key_q) ? ST_DONE : ST_PROBE;
			ST_DONE:  if (out_free) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		load_cmd = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				q_pop    = q_nonempty;
				mem_we   = q_nonempty && (q_cmd.op == OP_WRITE);
				load_cmd = q_nonempty && (q_cmd.op == OP_SEARCH);
			end
			ST_PROBE: mem_re = active;
			ST_DONE:  load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			lo_q   <= '0;
			hi_q   <= q_cmd.count;
			cnt_q  <= q_cmd.count;
			key_q  <= q_cmd.word;
			mode_q <= q_cmd.mode;
		end
		if (st_q == ST_PROBE) begin
			if (active) begin
				mid_q <= mid;
			end else begin
				res_pos_q   <= miss_pos;
				res_found_q <= 1'b0;
			end
		end
		if (st_q == ST_CMP) begin
			priority if (rdata_q > key_q) begin
				hi_q <= mid_q;
			end else if (rdata_q < key_q) begin
				lo_q <= mid_q + 1'b1;
			end else begin
				res_pos_q   <= mid_q;
				res_found_q <= 1'b1;
			end
		end
		if (load_out) begin
			out_pos_q   <= res_pos_q;
			out_found_q <= res_found_q;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[AW'(q_cmd.idx)] <= q_cmd.word;
		if (mem_re) rdata_q <= mem[AW'(mid)];
	end

	assign out_valid = out_valid_q;
	assign position  = out_pos_q;
	assign found     = out_found_q;

	`ASSERT_IMP(a_bounds, clk, arst_n, st_q == ST_PROBE || st_q == ST_CMP, lo_q <= hi_q && hi_q <= cnt_q)
	`ASSERT_IMP(a_mid_in_range, clk, arst_n, st_q == ST_CMP, mid_q >= lo_q && mid_q < hi_q)
	`ASSERT_NXT(a_probe_reads, clk, arst_n, st_q == ST_PROBE && lo_q < hi_q, st_q == ST_CMP)

endmodule
